### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ngga_pkg.sv
// Shared types, constants and lookup functions of the GGA position parser.
package ngga_pkg;

  localparam int ADD_W = 23;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] HDR_LEN  = 3'd6;
  localparam logic [3:0] CNT_MAX  = 4'd15;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] LAT_CHARS = 4'd7;
  localparam logic [3:0] LON_CHARS = 4'd8;

  localparam logic [19:0] LAT_ACC_MAX = 20'hFFFFF;
  localparam logic [20:0] LON_ACC_MAX = 21'h1FFFFF;

  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_LAT  = 3'd1,
    OP_NS   = 3'd2,
    OP_LON  = 3'd3,
    OP_EW   = 3'd4,
    OP_EMIT = 3'd5,
    OP_DROP = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             flag;
    logic [ADD_W-1:0] addend;
  } cmd_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24; // $
      3'd1:    ch = 8'h47; // G
      3'd2:    ch = 8'h50; // P
      3'd3:    ch = 8'h47; // G
      3'd4:    ch = 8'h47; // G
      3'd5:    ch = 8'h41; // A
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // ddmm.mm
  function automatic logic [19:0] lat_weight(input logic [3:0] pos);
    logic [19:0] w;
    unique case (pos)
      4'd0:    w = 20'd60000;
      4'd1:    w = 20'd6000;
      4'd2:    w = 20'd1000;
      4'd3:    w = 20'd100;
      4'd5:    w = 20'd10;
      4'd6:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

  // dddmm.mm
  function automatic logic [19:0] lon_weight(input logic [3:0] pos);
    logic [19:0] w;
    unique case (pos)
      4'd0:    w = 20'd600000;
      4'd1:    w = 20'd60000;
      4'd2:    w = 20'd6000;
      4'd3:    w = 20'd1000;
      4'd4:    w = 20'd100;
      4'd6:    w = 20'd10;
      4'd7:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/ngga_front.sv
// Front end: tracks header and field position per byte and emits commands.
module ngga_front import ngga_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] rx_byte,
  output cmd_t       cmd
);

  logic [2:0] hdr_pos_r, hdr_pos_nxt;
  logic       hdr_match_r, hdr_match_nxt;
  logic [3:0] field_r, field_nxt;
  logic [3:0] cif_r, cif_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] weight;
  logic [23:0] prod;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = is_digit ? rx_byte[3:0] : 4'd0;

  always_comb begin
    weight = 20'd0;
    if ((field_r == FLD_LAT) && (cif_r < LAT_CHARS)) begin
      weight = lat_weight(cif_r);
    end else if ((field_r == FLD_LON) && (cif_r < LON_CHARS)) begin
      weight = lon_weight(cif_r);
    end
  end

  assign prod = {20'd0, digit} * {4'd0, weight};

  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    hdr_match_nxt = hdr_match_r;
    field_nxt     = field_r;
    cif_nxt       = cif_r;
    cmd.op        = OP_NOP;
    cmd.flag      = 1'b0;
    cmd.addend    = prod[ADD_W-1:0];
    if (rx_byte == CH_NL) begin
      cmd.op        = (hdr_match_r && (hdr_pos_r == HDR_LEN)) ? OP_EMIT : OP_DROP;
      hdr_pos_nxt   = 3'd0;
      hdr_match_nxt = 1'b1;
      field_nxt     = 4'd0;
      cif_nxt       = 4'd0;
    end else begin
      if (hdr_pos_r < HDR_LEN) begin
        if (rx_byte != hdr_char(hdr_pos_r)) begin
          hdr_match_nxt = 1'b0;
        end
        hdr_pos_nxt = hdr_pos_r + 3'd1;
      end
      if (rx_byte == CH_COMMA) begin
        if (field_r < CNT_MAX) begin
          field_nxt = field_r + 4'd1;
        end
        cif_nxt = 4'd0;
      end else begin
        if (cif_r < CNT_MAX) begin
          cif_nxt = cif_r + 4'd1;
        end
        priority if (field_r == FLD_LAT) begin
          cmd.op = OP_LAT;
        end else if (field_r == FLD_LON) begin
          cmd.op = OP_LON;
        end else if ((field_r == FLD_NS) && (cif_r == 4'd0)) begin
          cmd.op   = OP_NS;
          cmd.flag = (rx_byte == CH_S);
        end else if ((field_r == FLD_EW) && (cif_r == 4'd0)) begin
          cmd.op   = OP_EW;
          cmd.flag = (rx_byte == CH_W);
        end else begin
          cmd.op = OP_NOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= 3'd0;
      hdr_match_r <= 1'b1;
      field_r     <= 4'd0;
      cif_r       <= 4'd0;
    end else if (push) begin
      hdr_pos_r   <= hdr_pos_nxt;
      hdr_match_r <= hdr_match_nxt;
      field_r     <= field_nxt;
      cif_r       <= cif_nxt;
    end
  end

endmodule

### hw/rtl/ngga_queue.sv
// Small command FIFO between the front end and the back end.
module ngga_queue import ngga_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

### hw/rtl/ngga_back.sv
// Back end: accumulates coordinates, applies hemispheres and holds the result word.
module ngga_back import ngga_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  cmd_t               cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] out_latitude,
  output logic               out_lat_valid,
  output logic signed [21:0] out_longitude,
  output logic               out_lon_valid
);

  logic [19:0] lat_acc_r;
  logic [20:0] lon_acc_r;
  logic        lat_pres_r, lon_pres_r, south_r, west_r;
  logic        out_valid_r, out_valid_nxt;
  logic [20:0] lat_r;
  logic [21:0] lon_r;
  logic        lat_v_r, lon_v_r;

  logic [20:0] lat_sum;
  logic [23:0] lon_sum;
  logic [19:0] lat_add_sat;
  logic [20:0] lon_add_sat;
  logic [20:0] lat_res;
  logic [21:0] lon_res;
  logic        lon_ok;
  logic        is_emit;

  assign is_emit = (cmd.op == OP_EMIT);
  assign pop     = !empty && (!is_emit || !out_valid_r || out_ready);

  assign lat_sum = {1'b0, lat_acc_r} + {1'b0, cmd.addend[19:0]};
  assign lon_sum = {3'd0, lon_acc_r} + {1'b0, cmd.addend};
  assign lat_add_sat = lat_sum[20] ? LAT_ACC_MAX : lat_sum[19:0];
  assign lon_add_sat = (lon_sum > {3'd0, LON_ACC_MAX}) ? LON_ACC_MAX : lon_sum[20:0];

  assign lon_ok  = lat_pres_r && lon_pres_r;
  assign lat_res = !lat_pres_r ? 21'd0 :
                   south_r ? (21'd0 - {1'b0, lat_acc_r}) : {1'b0, lat_acc_r};
  assign lon_res = !lon_ok ? 22'd0 :
                   west_r ? (22'd0 - {1'b0, lon_acc_r}) : {1'b0, lon_acc_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && is_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_acc_r   <= '0;
      lon_acc_r   <= '0;
      lat_pres_r  <= 1'b0;
      lon_pres_r  <= 1'b0;
      south_r     <= 1'b0;
      west_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        unique case (cmd.op)
          OP_LAT: begin
            lat_pres_r <= 1'b1;
            lat_acc_r  <= lat_add_sat;
          end
          OP_LON: begin
            lon_pres_r <= 1'b1;
            lon_acc_r  <= lon_add_sat;
          end
          OP_NS: south_r <= cmd.flag;
          OP_EW: west_r  <= cmd.flag;
          OP_EMIT, OP_DROP: begin
            lat_acc_r  <= '0;
            lon_acc_r  <= '0;
            lat_pres_r <= 1'b0;
            lon_pres_r <= 1'b0;
            south_r    <= 1'b0;
            west_r     <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_emit) begin
      lat_r   <= lat_res;
      lon_r   <= lon_res;
      lat_v_r <= lat_pres_r;
      lon_v_r <= lon_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_latitude  = lat_r;
  assign out_lat_valid = lat_v_r;
  assign out_longitude = lon_r;
  assign out_lon_valid = lon_v_r;

endmodule

### hw/rtl/nmea_gga_position_parser.sv
// NMEA GGA position parser: takes one received character per word and, at the end of
// each $GPGGA line, delivers one word with latitude and longitude in hundredths of an
// arc-minute (south and west negative) plus their present flags; other lines deliver
// nothing. A character is taken every cycle: the front end classifies it
// combinationally, a QUEUE_DEPTH-entry FIFO carries the command, and the back end
// retires one command per cycle. A finished result waits in the output register;
// only a line end that meets a still-unaccepted result stalls the back end, and
// input stalls once the FIFO fills. out_valid is registered and rises after the back
// end retires the line end's command, held back while an earlier result still waits.
module nmea_gga_position_parser import ngga_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] out_latitude,
  output logic               out_lat_valid,
  output logic signed [21:0] out_longitude,
  output logic               out_lon_valid
);

  cmd_t front_cmd, back_cmd;
  logic push, pop, full, empty;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  ngga_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_rx_byte),
    .cmd     (front_cmd)
  );

  ngga_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_cmd  (back_cmd)
  );

  ngga_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .cmd           (back_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_latitude  (out_latitude),
    .out_lat_valid (out_lat_valid),
    .out_longitude (out_longitude),
    .out_lon_valid (out_lon_valid)
  );

endmodule

### hw/rtl/ngga_checker.sv
// Port-level assertions for the GGA position parser and their bind.
`include "assert_macros.svh"

module ngga_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [20:0] out_latitude,
  input logic               out_lat_valid,
  input logic signed [21:0] out_longitude,
  input logic               out_lon_valid
);

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `CHK_IMPL(a_lat_zero, out_valid && !out_lat_valid, out_latitude == 21'sd0, "latitude not zero")
  `CHK_IMPL(a_lon_needs_lat, out_valid && out_lon_valid, out_lat_valid, "lon valid without lat")
  `CHK_IMPL(a_lon_zero, out_valid && !out_lon_valid, out_longitude == 22'sd0, "longitude not zero")

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench of the GGA position parser: directed NMEA lines, then random traffic checked by a model.
module testbench;
  import ngga_pkg::*;

  typedef struct packed {
    logic signed [20:0] lat;
    logic               lat_ok;
    logic signed [21:0] lon;
    logic               lon_ok;
  } fix_t;

  typedef struct {
    string text;
    bit    typed;
    fix_t  want;
  } probe_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [20:0] out_latitude;
  logic               out_lat_valid;
  logic signed [21:0] out_longitude;
  logic               out_lon_valid;

  nmea_gga_position_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_latitude (out_latitude),
    .out_lat_valid(out_lat_valid),
    .out_longitude(out_longitude),
    .out_lon_valid(out_lon_valid)
  );

  always #4 clk = ~clk;

  // line tracker state
  logic [2:0]  tag_pos = '0;
  logic        tag_ok = 1'b1;
  logic [3:0]  field_no = '0;
  logic [3:0]  col = '0;
  logic [19:0] lat_sum = '0;
  logic [20:0] lon_sum = '0;
  logic        have_lat = 1'b0;
  logic        have_lon = 1'b0;
  logic        is_south = 1'b0;
  logic        is_west = 1'b0;

  string       gga_tag = "$GPGGA";
  int unsigned lat_scale[7] = '{60000, 6000, 1000, 100, 0, 10, 1};
  int unsigned lon_scale[8] = '{600000, 60000, 6000, 1000, 100, 0, 10, 1};

  fix_t        pending_fixes[$];
  logic [7:0]  line_bytes[$];
  int          errors = 0;
  int          send_idle_pct = 33;
  int          recv_idle_pct = 67;
  int          holds_asked = 0;

  probe_row_t probes[$] = '{
    '{"$GPGGA,123519,4807.03,N,01131.00,E,1\n", 1'b1, '{21'sd288703, 1'b1, 22'sd69100, 1'b1}},
    '{"$GPGGA,,8959.99,S,17959.99,W\n", 1'b1,
      '{-21'sd539999, 1'b1, -22'sd1079999, 1'b1}},
    '{"$GPGGA,,0000.00,N,00000.00,E\n", 1'b1, '{21'sd0, 1'b1, 22'sd0, 1'b1}},
    '{"$GPGGA,235959,,N,12345.67,W\n", 1'b1, '{21'sd0, 1'b0, 22'sd0, 1'b0}},
    '{"$GPGGA,0,1234.56,S,,W\n", 1'b1, '{-21'sd75456, 1'b1, 22'sd0, 1'b0}},
    '{"$GPGGA,,9999.99,S,99999.99,W\n", 1'b0, '0},
    '{"$GPGGA,,9999.99,N,34999.99,E\n", 1'b0, '0},
    '{"$GPGGA,,4a07#0b,N,0x1 1.0?,E\n", 1'b0, '0},
    '{"$GPGGA,,4807.0399,N,01131.0077,E\n", 1'b0, '0},
    '{"$GPGGA,,1000.00,SOUTH,01000.00,w\n", 1'b0, '0},
    '{"$GPGGA,,1000.00,NS,01000.00,EW\n", 1'b0, '0},
    '{"$GPGGAX,1,0100.00,N,00100.00,W\n", 1'b0, '0},
    '{"$GPG\n", 1'b0, '0},
    '{"\n", 1'b0, '0},
    '{"$GPGGA,1,2233.44\n", 1'b0, '0},
    '{"$GPGGA\n", 1'b0, '0},
    '{"$GPRMC,1,4807.03,N,01131.00,E\n", 1'b0, '0},
    '{"$GPGGA,,,,,,,,,,,,,,,,,,,7777777777777777777\n", 1'b0, '0},
    '{"$GPGGA,123456789012345678,1234.5678901234567,S,00001.00,W,x*5B\n", 1'b0, '0}
  };

  function automatic void clear_line_state();
    tag_pos = '0;
    tag_ok = 1'b1;
    field_no = '0;
    col = '0;
    lat_sum = '0;
    lon_sum = '0;
    have_lat = 1'b0;
    have_lon = 1'b0;
    is_south = 1'b0;
    is_west = 1'b0;
  endfunction

  // Returns 1 when the character closes a GGA line; fix then holds the position word.
  function automatic bit track_char(input logic [7:0] c, output fix_t fix);
    int unsigned pos;
    int unsigned d;
    int unsigned sum;
    bit          digit;
    bit          emit;
    fix = '0;
    if (c == CH_NL) begin
      emit = (tag_pos == HDR_LEN) && tag_ok;
      fix.lat_ok = have_lat;
      fix.lon_ok = have_lat && have_lon;
      if (fix.lat_ok) fix.lat = 21'(is_south ? -int'(lat_sum) : int'(lat_sum));
      if (fix.lon_ok) fix.lon = 22'(is_west ? -int'(lon_sum) : int'(lon_sum));
      clear_line_state();
      return emit;
    end
    if (tag_pos < HDR_LEN) begin
      if (c != gga_tag[tag_pos]) tag_ok = 1'b0;
      tag_pos++;
    end
    if (c == CH_COMMA) begin
      if (field_no < CNT_MAX) field_no++;
      col = '0;
      return 1'b0;
    end
    pos = col;
    if (col < CNT_MAX) col++;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = digit ? int'(c - CH_ZERO) : 0;
    case (field_no)
      FLD_LAT: begin
        have_lat = 1'b1;
        if (digit && pos < LAT_CHARS) begin
          sum = lat_sum + d * lat_scale[pos];
          lat_sum = (sum > LAT_ACC_MAX) ? LAT_ACC_MAX : sum[19:0];
        end
      end
      FLD_NS: if (pos == 0) is_south = (c == CH_S);
      FLD_LON: begin
        have_lon = 1'b1;
        if (digit && pos < LON_CHARS) begin
          sum = lon_sum + d * lon_scale[pos];
          lon_sum = (sum > LON_ACC_MAX) ? LON_ACC_MAX : sum[20:0];
        end
      end
      FLD_EW: if (pos == 0) is_west = (c == CH_W);
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic check_word();
    fix_t want;
    if (pending_fixes.size() == 0) begin
      report_mismatch("word with none pending", 64'sd1, 64'sd0);
      return;
    end
    want = pending_fixes.pop_front();
    if (out_latitude !== want.lat)
      report_mismatch("latitude", longint'(out_latitude), longint'(want.lat));
    if (out_lat_valid !== want.lat_ok)
      report_mismatch("lat_valid", longint'(out_lat_valid), longint'(want.lat_ok));
    if (out_longitude !== want.lon)
      report_mismatch("longitude", longint'(out_longitude), longint'(want.lon));
    if (out_lon_valid !== want.lon_ok)
      report_mismatch("lon_valid", longint'(out_lon_valid), longint'(want.lon_ok));
  endtask

  task automatic send_char(input logic [7:0] c, input bit typed, input fix_t want);
    fix_t fix;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    do @(posedge clk); while (!in_ready);
    if (track_char(c, fix)) begin
      pending_fixes.push_back(typed ? want : fix);
    end
  endtask

  task automatic drain_fixes();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_fixes.size() != 0);
  endtask

  task automatic push_digits(input int count, input int top);
    repeat (count) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, top)));
  endtask

  task automatic build_fix_line();
    int cut;
    line_bytes.delete();
    for (int k = 0; k < 6; k++) line_bytes.push_back(gga_tag[k]);
    if ($urandom_range(0, 9) == 0) begin
      line_bytes[$urandom_range(0, 5)] = 8'($urandom_range(33, 126));
    end
    if ($urandom_range(0, 15) == 0) line_bytes.push_back(8'($urandom_range(65, 90)));
    line_bytes.push_back(CH_COMMA);
    push_digits($urandom_range(0, 10), 9);
    line_bytes.push_back(CH_COMMA);
    if ($urandom_range(0, 9) != 0) begin
      push_digits(1, ($urandom_range(0, 9) == 0) ? 9 : 8);
      push_digits(1, 9);
      push_digits(1, 5);
      push_digits(1, 9);
      line_bytes.push_back(".");
      push_digits(2, 9);
      if ($urandom_range(0, 7) == 0) push_digits($urandom_range(1, 10), 9);
      if ($urandom_range(0, 9) == 0)
        line_bytes[line_bytes.size() - $urandom_range(1, 7)] = 8'($urandom_range(33, 126));
    end
    line_bytes.push_back(CH_COMMA);
    case ($urandom_range(0, 7))
      0: ;
      1: line_bytes.push_back(8'($urandom_range(33, 126)));
      default: line_bytes.push_back($urandom_range(0, 1) ? CH_S : "N");
    endcase
    line_bytes.push_back(CH_COMMA);
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 7) == 0) push_digits(3, 9);
      else begin
        push_digits(1, 1);
        push_digits(1, ($urandom_range(0, 1) == 0) ? 7 : 9);
        push_digits(1, 9);
      end
      push_digits(1, 5);
      push_digits(1, 9);
      line_bytes.push_back(".");
      push_digits(2, 9);
      if ($urandom_range(0, 7) == 0) push_digits($urandom_range(1, 10), 9);
      if ($urandom_range(0, 9) == 0)
        line_bytes[line_bytes.size() - $urandom_range(1, 8)] = 8'($urandom_range(33, 126));
    end
    line_bytes.push_back(CH_COMMA);
    case ($urandom_range(0, 7))
      0: ;
      1: line_bytes.push_back(8'($urandom_range(33, 126)));
      default: line_bytes.push_back($urandom_range(0, 1) ? CH_W : "E");
    endcase
    repeat ($urandom_range(0, 12)) begin
      line_bytes.push_back(CH_COMMA);
      push_digits($urandom_range(0, 3), 9);
    end
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(0, line_bytes.size() - 1);
      line_bytes = line_bytes[0:cut];
    end
    line_bytes.push_back(CH_NL);
  endtask

  task automatic build_noise_line();
    logic [7:0] b;
    line_bytes.delete();
    repeat ($urandom_range(0, 24)) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
      line_bytes.push_back(b);
    end
    if ($urandom_range(0, 3) != 0) line_bytes.push_back(CH_NL);
  endtask

  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_word();
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    fix_t none;
    int   phase;
    int   chars_sent;
    none = '0;
    phase = 0;
    chars_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[r]) begin
      for (int i = 0; i < probes[r].text.len(); i++)
        send_char(probes[r].text[i], probes[r].typed, probes[r].want);
      chars_sent += probes[r].text.len();
    end

    while (chars_sent < 1500) begin
      if (phase == 0 && chars_sent >= 500) begin
        drain_fixes();
        send_idle_pct = 67;
        recv_idle_pct = 33;
        phase = 1;
      end else if (phase == 1 && chars_sent >= 1000) begin
        drain_fixes();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver stall while the sender keeps pushing line ends
        holds_asked++;
        repeat (8) begin
          for (int k = 0; k < 6; k++) send_char(gga_tag[k], 1'b0, none);
          send_char(CH_NL, 1'b0, none);
        end
        chars_sent += 56;
        drain_fixes();
        phase = 2;
      end
      if ($urandom_range(0, 99) < 85) begin
        build_fix_line();
      end else begin
        build_noise_line();
      end
      chars_sent += line_bytes.size();
      foreach (line_bytes[k]) send_char(line_bytes[k], 1'b0, none);
    end

    drain_fixes();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
